FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the line history recall RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond)

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/tlhr_pkg.sv
// Types, codes and constants of the typed line history recall unit.
package tlhr_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int LINE_MAX_DEF      = 31;
  localparam int LEN_W             = 5;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0] ACT_TYPE = 2'd0;
  localparam logic [1:0] ACT_BACK = 2'd1;
  localparam logic [1:0] ACT_FWD  = 2'd2;

  localparam logic [7:0] CODE_ENTER = 8'h0d;
  localparam logic [7:0] CODE_ERASE = 8'h08;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_ERASE,
    OP_ENTER,
    OP_BACK,
    OP_FWD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_ERASE,
    ST_LOAD_RD,
    ST_LOAD_WR
  } back_state_e;

  typedef struct packed {
    logic             idle;
    logic [LEN_W-1:0] line_len;
  } back_status_t;

endpackage

FILE: rtl/core/tlhr_queue.sv
// Short command queue between the front decoder and the back sequencer.
module tlhr_queue
  import tlhr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o     = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/tlhr_front.sv
// Input side: takes stream transactions and decodes them into queue commands.
module tlhr_front
  import tlhr_pkg::*;
(
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic [1:0] s_axis_tuser_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_data_o
);

  op_e op;

  always_comb begin
    op = OP_NONE;
    unique case (s_axis_tuser_i)
      ACT_TYPE: begin
        case (s_axis_tdata_i)
          CODE_ENTER: op = OP_ENTER;
          CODE_ERASE: op = OP_ERASE;
          default:    op = OP_APPEND;
        endcase
      end
      ACT_BACK: op = OP_BACK;
      ACT_FWD:  op = OP_FWD;
      default:  op = OP_NONE;
    endcase
  end

  // An unused action is taken and dropped here; it never reaches the queue.
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i && (op != OP_NONE);
  assign q_data_o.op     = op;
  assign q_data_o.ch     = s_axis_tdata_i;

endmodule

FILE: rtl/core/tlhr_back.sv
// Back sequencer: line editing, history ring store, erase and retype runs.
module tlhr_back
  import tlhr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LINE_MAX      = LINE_MAX_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  cmd_t         q_data_i,
  output logic         q_pop_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [7:0]   m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  output back_status_t status_o
);

  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int LIW = $clog2(LINE_MAX);
  localparam int AW  = HW + LIW;

  back_state_e      state_q, state_d;
  logic [HW-1:0]    head_q, head_d;
  logic [HW-1:0]    ptr_q, ptr_d;
  logic [HW-1:0]    phys_q, phys_d;
  logic [LEN_W-1:0] line_len_q, line_len_d;
  logic [LEN_W-1:0] load_len_q, load_len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LIW-1:0]   idx_q, idx_d;
  logic [LEN_W-1:0] hist_len_q [HISTORY_DEPTH];

  logic [7:0]       line_q [LINE_MAX];
  logic [7:0]       hist_mem [2**AW];
  logic [7:0]       rd_data_q;

  logic             out_valid_q, out_last_q;
  logic [7:0]       out_char_q;
  logic             out_free, emit, emit_last;
  logic [7:0]       emit_char;

  logic             line_we;
  logic [LIW-1:0]   line_wa;
  logic [7:0]       line_wd;
  logic             len_we;
  logic [HW-1:0]    len_wa;
  logic             mem_we;
  logic [AW-1:0]    rd_addr;

  logic [HW-1:0]    head_dec;
  logic [HW-1:0]    slot;
  logic [HW:0]      phys_sum;
  logic [HW-1:0]    phys_calc;
  logic [LEN_W-1:0] slot_len;
  logic [LEN_W-1:0] idx_ext;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign idx_ext  = LEN_W'(idx_q);
  assign head_dec = (head_q == '0) ? HW'(HISTORY_DEPTH - 1) : head_q - HW'(1);
  assign rd_addr  = {phys_q, idx_q};

  // Slot to physical entry of the history ring; slot 0 sits at the head.
  always_comb begin
    slot = ptr_q;
    if (q_data_i.op == OP_FWD && ptr_q != '0) begin
      slot = ptr_q - HW'(1);
    end
    phys_sum = {1'b0, head_q} + {1'b0, slot};
    if (phys_sum >= (HW+1)'(HISTORY_DEPTH)) begin
      phys_calc = HW'(phys_sum - (HW+1)'(HISTORY_DEPTH));
    end else begin
      phys_calc = phys_sum[HW-1:0];
    end
    slot_len = hist_len_q[phys_calc];
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    ptr_d      = ptr_q;
    phys_d     = phys_q;
    line_len_d = line_len_q;
    load_len_d = load_len_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    q_pop_o    = 1'b0;
    line_we    = 1'b0;
    line_wa    = idx_q;
    line_wd    = rd_data_q;
    len_we     = 1'b0;
    len_wa     = head_dec;
    mem_we     = 1'b0;
    emit       = 1'b0;
    emit_char  = CODE_ERASE;
    emit_last  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_data_i.op)
            OP_APPEND: begin
              if (line_len_q < LEN_W'(LINE_MAX)) begin
                line_we    = 1'b1;
                line_wa    = line_len_q[LIW-1:0];
                line_wd    = q_data_i.ch;
                line_len_d = line_len_q + LEN_W'(1);
              end
            end
            OP_ERASE: begin
              if (line_len_q != '0) begin
                line_len_d = line_len_q - LEN_W'(1);
              end
            end
            OP_ENTER: begin
              head_d     = head_dec;
              len_we     = 1'b1;
              ptr_d      = '0;
              cnt_d      = line_len_q;
              idx_d      = '0;
              line_len_d = '0;
              if (line_len_q != '0) begin
                state_d = ST_STORE;
              end
            end
            OP_BACK, OP_FWD: begin
              if (q_data_i.op == OP_BACK) begin
                ptr_d = (ptr_q == HW'(HISTORY_DEPTH - 1)) ? ptr_q : ptr_q + HW'(1);
              end else begin
                ptr_d = slot;
              end
              phys_d     = phys_calc;
              load_len_d = slot_len;
              cnt_d      = line_len_q;
              line_len_d = slot_len;
              idx_d      = '0;
              if (line_len_q != '0) begin
                state_d = ST_ERASE;
              end else if (slot_len != '0) begin
                state_d = ST_LOAD_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STORE: begin
        mem_we = 1'b1;
        idx_d  = idx_q + LIW'(1);
        if (idx_ext == cnt_q - LEN_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERASE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CODE_ERASE;
          emit_last = (cnt_q == LEN_W'(1)) && (load_len_q == '0);
          cnt_d     = cnt_q - LEN_W'(1);
          if (cnt_q == LEN_W'(1)) begin
            state_d = (load_len_q != '0) ? ST_LOAD_RD : ST_IDLE;
          end
        end
      end
      ST_LOAD_RD: begin
        state_d = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        // The read address holds here, so the registered data waits out a stall.
        if (out_free) begin
          emit      = 1'b1;
          emit_char = rd_data_q;
          emit_last = (idx_ext == load_len_q - LEN_W'(1));
          line_we   = 1'b1;
          idx_d     = idx_q + LIW'(1);
          state_d   = emit_last ? ST_IDLE : ST_LOAD_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      ptr_q       <= '0;
      line_len_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_len_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      ptr_q      <= ptr_d;
      line_len_q <= line_len_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (len_we) begin
        hist_len_q[len_wa] <= line_len_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    phys_q     <= phys_d;
    load_len_q <= load_len_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
    if (line_we) begin
      line_q[line_wa] <= line_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[{head_q, idx_q}] <= line_q[idx_q];
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_char_q;
  assign m_axis_tlast_o    = out_last_q;
  assign status_o.idle     = (state_q == ST_IDLE);
  assign status_o.line_len = line_len_q;

endmodule

FILE: rtl/core/typed_line_history_recall_unit.sv
// Top level of the typed line history recall unit.
//
//  channel  | dir | tdata        | tuser       | tlast
//  s_axis   | in  | char_code    | action      | -
//  m_axis   | out | out_char     | -           | last
//
// A typed byte or a backspace passes through the command queue and edits the line in the idle state.
// A carriage return writes the line into the history memory a character at a time,
// since the history memory has a single write port.
// A recall first emits one backspace per character of the current line, then
// retypes the recalled line, each byte read through the registered read of the
// history memory in ST_LOAD_RD and emitted in ST_LOAD_WR.
// Reset clears the line, the pointer and every history length; no clearing pass.
// The output register holds a byte while the sink stalls; the two-entry
// command queue keeps accepting until it is full.
`include "assert_macros.svh"

module typed_line_history_recall_unit
  import tlhr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LINE_MAX      = LINE_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic [1:0] s_axis_tuser_i,   // [1:0] action
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o
);

  logic         q_full, q_push, q_valid, q_pop;
  cmd_t         q_wdata, q_rdata;
  back_status_t back_status;

  tlhr_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  tlhr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  tlhr_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LINE_MAX      (LINE_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .status_o        (back_status)
  );

  `ASSERT_ALWAYS(a_line_len_bound, clk_i, rst_ni, back_status.line_len <= LEN_W'(LINE_MAX))
  `ASSERT_IMPLY(a_pop_when_idle, clk_i, rst_ni, q_pop, back_status.idle && q_valid)
  `ASSERT_IMPLY(a_idle_run_closed, clk_i, rst_ni, back_status.idle && m_axis_tvalid_o, m_axis_tlast_o)

endmodule
